>>> hw/rtl/omp_pkg.sv
// Shared types, constants and sine table for the omni wheel polar mixer.
package omp_pkg;

	localparam int NUM_WHEELS    = 4;
	localparam int HEADING_W     = 9;
	localparam int POWER_W       = 8;
	localparam int ROT_W         = 8;
	localparam int GAIN_W        = 8;
	localparam int ANGLE_W       = 9;
	localparam int SINE_W        = 15;
	localparam int SINE_IDX_W    = 7;
	localparam int SINE_ENTRIES  = 91;
	localparam int PROD_W        = 22;   // sine magnitude times power magnitude
	localparam int SCALED_W      = 30;   // and times gain
	localparam int ROTTERM_W     = 29;   // signed rotation term
	localparam int SUM_W         = 31;   // signed wheel term
	localparam int MAG_W         = 30;
	localparam int IN_W          = 32;
	localparam int CFG_INDEX_W   = 2;
	localparam int DUTY_BITS_DEF = 10;

	localparam logic [ANGLE_W:0]   FULL_CIRCLE   = 10'd360;
	localparam logic [ANGLE_W-1:0] QUARTER_TURN  = 9'd90;
	localparam logic [ANGLE_W-1:0] HALF_TURN     = 9'd180;
	localparam logic [ANGLE_W-1:0] THREE_QUARTER = 9'd270;
	localparam logic [ANGLE_W-1:0] WHOLE_TURN    = 9'd360;

	// 90 + wheel offset, folded into one turn
	localparam logic [ANGLE_W-1:0] WHEEL_BASE [NUM_WHEELS] = '{9'd120, 9'd240, 9'd315, 9'd45};

	localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd100;

	// full scale is 163840000 = 2^18 * 625 term units
	localparam int ROT_UNIT     = 1474560;
	localparam int HALF_DEN     = 81920000;
	localparam int DEN_SHIFT    = 18;
	localparam int DEN_ODD      = 625;
	localparam int DEN_ODD_LOG  = 10;

	// directions on a stop command, wheel one in bit 0
	localparam logic [NUM_WHEELS-1:0] STOP_DIR = 4'b0011;

	localparam logic [SINE_W-1:0] SINE_Q14 [SINE_ENTRIES] = '{
		15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
		15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
		15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
		15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
		15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
		15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
		15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
		15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
		15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
		15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
		15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
		15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
		15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
	};

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_GAIN_ONE,
		REG_GAIN_TWO,
		REG_GAIN_THREE,
		REG_GAIN_FOUR
	} cfg_reg_t;

	typedef logic [NUM_WHEELS-1:0][GAIN_W-1:0] gain_vec_t;

	typedef struct packed {
		logic [ROT_W-1:0]     rot;
		logic [POWER_W-1:0]   power;
		logic [HEADING_W-1:0] heading;
	} cmd_t;

	typedef struct packed {
		logic              neg;
		logic [SINE_W-1:0] mag;
	} sine_t;

	typedef struct packed {
		logic                        stop;
		logic                        pneg;
		logic [POWER_W-1:0]          pmag;
		logic [ROT_W-1:0]            rot;
		sine_t [NUM_WHEELS-1:0]      sine;
	} trig_t;

	typedef struct packed {
		logic                              stop;
		logic [NUM_WHEELS-1:0]             dir;
		logic [NUM_WHEELS-1:0][MAG_W-1:0]  mag;
	} mix_t;

endpackage

>>> hw/rtl/omp_angle.sv
// Heading reduction, wheel angles and quarter-wave sine lookup (two stages).
module omp_angle (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  omp_pkg::cmd_t in_cmd,
	output logic          out_valid,
	input  logic          out_ready,
	output omp_pkg::trig_t out_trig
);

	logic en_s1, en_s2;
	logic v_s1, v_s2;

	logic [omp_pkg::ANGLE_W-1:0] head_d;
	logic [omp_pkg::ANGLE_W:0]   sum_d [omp_pkg::NUM_WHEELS];
	logic [omp_pkg::ANGLE_W-1:0] ang_d [omp_pkg::NUM_WHEELS];
	logic                        pneg_d;
	logic [omp_pkg::POWER_W-1:0] pmag_d;

	logic [omp_pkg::ANGLE_W-1:0] ang_s1 [omp_pkg::NUM_WHEELS];
	logic                        stop_s1;
	logic                        pneg_s1;
	logic [omp_pkg::POWER_W-1:0] pmag_s1;
	logic [omp_pkg::ROT_W-1:0]   rot_s1;

	logic [omp_pkg::SINE_IDX_W-1:0] idx_d [omp_pkg::NUM_WHEELS];
	logic                           sneg_d [omp_pkg::NUM_WHEELS];
	omp_pkg::trig_t                 trig_d;
	omp_pkg::trig_t                 trig_s2;

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// stage 1: heading mod 360, per-wheel angle, power sign and magnitude
	always_comb begin
		head_d = (in_cmd.heading >= omp_pkg::WHOLE_TURN) ?
			in_cmd.heading - omp_pkg::WHOLE_TURN : in_cmd.heading;
		for (int w = 0; w < omp_pkg::NUM_WHEELS; w++) begin
			sum_d[w] = {1'b0, omp_pkg::WHEEL_BASE[w]} + omp_pkg::FULL_CIRCLE - {1'b0, head_d};
			if (sum_d[w] >= omp_pkg::FULL_CIRCLE) begin
				ang_d[w] = omp_pkg::ANGLE_W'(sum_d[w] - omp_pkg::FULL_CIRCLE);
			end else begin
				ang_d[w] = omp_pkg::ANGLE_W'(sum_d[w]);
			end
		end
		pneg_d = in_cmd.power[omp_pkg::POWER_W-1];
		pmag_d = pneg_d ? (~in_cmd.power + 1'b1) : in_cmd.power;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			ang_s1  <= ang_d;
			stop_s1 <= (in_cmd.power == '0);
			pneg_s1 <= pneg_d;
			pmag_s1 <= pmag_d;
			rot_s1  <= in_cmd.rot;
		end
	end

	// stage 2: fold each angle onto the first quadrant and look up the sine
	always_comb begin
		for (int w = 0; w < omp_pkg::NUM_WHEELS; w++) begin
			priority if (ang_s1[w] <= omp_pkg::QUARTER_TURN) begin
				idx_d[w]  = omp_pkg::SINE_IDX_W'(ang_s1[w]);
				sneg_d[w] = 1'b0;
			end else if (ang_s1[w] <= omp_pkg::HALF_TURN) begin
				idx_d[w]  = omp_pkg::SINE_IDX_W'(omp_pkg::HALF_TURN - ang_s1[w]);
				sneg_d[w] = 1'b0;
			end else if (ang_s1[w] <= omp_pkg::THREE_QUARTER) begin
				idx_d[w]  = omp_pkg::SINE_IDX_W'(ang_s1[w] - omp_pkg::HALF_TURN);
				sneg_d[w] = 1'b1;
			end else begin
				idx_d[w]  = omp_pkg::SINE_IDX_W'(omp_pkg::WHOLE_TURN - ang_s1[w]);
				sneg_d[w] = 1'b1;
			end
		end
		trig_d.stop = stop_s1;
		trig_d.pneg = pneg_s1;
		trig_d.pmag = pmag_s1;
		trig_d.rot  = rot_s1;
		for (int w = 0; w < omp_pkg::NUM_WHEELS; w++) begin
			trig_d.sine[w].neg = sneg_d[w];
			trig_d.sine[w].mag = omp_pkg::SINE_Q14[idx_d[w]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			trig_s2 <= trig_d;
		end
	end

	assign out_valid = v_s2;
	assign out_trig  = trig_s2;

endmodule

>>> hw/rtl/omp_scale.sv
// Power and gain multiplies plus rotation sum per wheel (three stages).
module omp_scale (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  omp_pkg::trig_t     in_trig,
	input  omp_pkg::gain_vec_t gain,
	output logic               out_valid,
	input  logic               out_ready,
	output omp_pkg::mix_t      out_mix
);

	logic en_s3, en_s4, en_s5;
	logic v_s3, v_s4, v_s5;

	logic [omp_pkg::PROD_W-1:0]            prod_d [omp_pkg::NUM_WHEELS];
	logic signed [omp_pkg::ROTTERM_W-1:0]  rotterm_d;

	logic [omp_pkg::PROD_W-1:0]            prod_s3 [omp_pkg::NUM_WHEELS];
	logic [omp_pkg::NUM_WHEELS-1:0]        neg_s3;
	logic signed [omp_pkg::ROTTERM_W-1:0]  rotterm_s3;
	logic                                  stop_s3;

	logic [omp_pkg::SCALED_W-1:0]          scaled_d [omp_pkg::NUM_WHEELS];
	logic [omp_pkg::SCALED_W-1:0]          scaled_s4 [omp_pkg::NUM_WHEELS];
	logic [omp_pkg::NUM_WHEELS-1:0]        neg_s4;
	logic signed [omp_pkg::ROTTERM_W-1:0]  rotterm_s4;
	logic                                  stop_s4;

	logic signed [omp_pkg::SUM_W-1:0]      term_d [omp_pkg::NUM_WHEELS];
	logic signed [omp_pkg::SUM_W-1:0]      sum_d [omp_pkg::NUM_WHEELS];
	omp_pkg::mix_t                         mix_d;
	omp_pkg::mix_t                         mix_s5;

	assign en_s5    = !v_s5 || out_ready;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign in_ready = en_s3;

	// stage 3: |sine| * |power|, rotation term by constant
	always_comb begin
		for (int w = 0; w < omp_pkg::NUM_WHEELS; w++) begin
			prod_d[w] = omp_pkg::PROD_W'(in_trig.sine[w].mag) *
				omp_pkg::PROD_W'(in_trig.pmag);
		end
		rotterm_d = omp_pkg::ROTTERM_W'($signed(in_trig.rot)) *
			omp_pkg::ROTTERM_W'(omp_pkg::ROT_UNIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && in_valid) begin
			prod_s3    <= prod_d;
			rotterm_s3 <= rotterm_d;
			stop_s3    <= in_trig.stop;
			for (int w = 0; w < omp_pkg::NUM_WHEELS; w++) begin
				neg_s3[w] <= in_trig.sine[w].neg ^ in_trig.pneg;
			end
		end
	end

	// stage 4: times wheel gain
	always_comb begin
		for (int w = 0; w < omp_pkg::NUM_WHEELS; w++) begin
			scaled_d[w] = omp_pkg::SCALED_W'(prod_s3[w]) * omp_pkg::SCALED_W'(gain[w]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			scaled_s4  <= scaled_d;
			neg_s4     <= neg_s3;
			rotterm_s4 <= rotterm_s3;
			stop_s4    <= stop_s3;
		end
	end

	// stage 5: signed sum, then sign and magnitude
	always_comb begin
		mix_d.stop = stop_s4;
		for (int w = 0; w < omp_pkg::NUM_WHEELS; w++) begin
			term_d[w] = $signed({1'b0, scaled_s4[w]});
			if (neg_s4[w]) begin
				term_d[w] = -term_d[w];
			end
			sum_d[w] = term_d[w] + omp_pkg::SUM_W'(rotterm_s4);
			mix_d.dir[w] = (sum_d[w] > 0);
			mix_d.mag[w] = (sum_d[w] < 0) ? omp_pkg::MAG_W'(-sum_d[w]) :
				omp_pkg::MAG_W'(sum_d[w]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en_s5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5 && v_s4) begin
			mix_s5 <= mix_d;
		end
	end

	assign out_valid = v_s5;
	assign out_mix   = mix_s5;

endmodule

>>> hw/rtl/omp_duty.sv
// Magnitude to rounded, saturated duty via reciprocal multiply (two stages).
module omp_duty #(
	parameter int DUTY_BITS = omp_pkg::DUTY_BITS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_valid,
	output logic                                       in_ready,
	input  omp_pkg::mix_t                              in_mix,
	output logic                                       out_valid,
	input  logic                                       out_ready,
	output logic [omp_pkg::NUM_WHEELS-1:0][DUTY_BITS-1:0] duty,
	output logic [omp_pkg::NUM_WHEELS-1:0]             dir
);

	localparam int Y_W         = omp_pkg::MAG_W + DUTY_BITS;
	localparam int Z_W         = Y_W - omp_pkg::DEN_SHIFT;
	localparam int RECIP_SHIFT = Z_W + omp_pkg::DEN_ODD_LOG;
	localparam int M_W         = Z_W + 1;
	localparam int P_W         = Z_W + M_W;
	localparam int Q_W         = P_W - RECIP_SHIFT;
	localparam logic [M_W-1:0] RECIP = M_W'(((longint'(1) << RECIP_SHIFT) +
		longint'(omp_pkg::DEN_ODD) - longint'(1)) / longint'(omp_pkg::DEN_ODD));
	localparam logic [DUTY_BITS-1:0] DMAX = '1;

	logic en_s6, en_s7;
	logic v_s6, v_s7;

	logic [Y_W-1:0]                 y_d [omp_pkg::NUM_WHEELS];
	logic [Z_W-1:0]                 z_s6 [omp_pkg::NUM_WHEELS];
	logic [omp_pkg::NUM_WHEELS-1:0] dir_s6;
	logic                           stop_s6;

	logic [P_W-1:0]                 p_d [omp_pkg::NUM_WHEELS];
	logic [Q_W-1:0]                 q_d [omp_pkg::NUM_WHEELS];
	logic [omp_pkg::NUM_WHEELS-1:0][DUTY_BITS-1:0] duty_d;
	logic [omp_pkg::NUM_WHEELS-1:0][DUTY_BITS-1:0] duty_s7;
	logic [omp_pkg::NUM_WHEELS-1:0] dir_s7;

	assign en_s7    = !v_s7 || out_ready;
	assign en_s6    = !v_s6 || en_s7;
	assign in_ready = en_s6;

	// stage 6: mag * (2^N - 1) + half, drop the power-of-two part of the divisor
	always_comb begin
		for (int w = 0; w < omp_pkg::NUM_WHEELS; w++) begin
			y_d[w] = (Y_W'(in_mix.mag[w]) << DUTY_BITS) - Y_W'(in_mix.mag[w]) +
				Y_W'(omp_pkg::HALF_DEN);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en_s6) begin
			v_s6 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6 && in_valid) begin
			for (int w = 0; w < omp_pkg::NUM_WHEELS; w++) begin
				z_s6[w] <= y_d[w][Y_W-1:omp_pkg::DEN_SHIFT];
			end
			dir_s6  <= in_mix.dir;
			stop_s6 <= in_mix.stop;
		end
	end

	// stage 7: exact floor divide by 625, saturate, stop override
	always_comb begin
		for (int w = 0; w < omp_pkg::NUM_WHEELS; w++) begin
			p_d[w] = P_W'(z_s6[w]) * P_W'(RECIP);
			q_d[w] = p_d[w][P_W-1:RECIP_SHIFT];
			if (stop_s6) begin
				duty_d[w] = '0;
			end else if (q_d[w] > Q_W'(DMAX)) begin
				duty_d[w] = DMAX;
			end else begin
				duty_d[w] = DUTY_BITS'(q_d[w]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en_s7) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s7 && v_s6) begin
			duty_s7 <= duty_d;
			dir_s7  <= stop_s6 ? omp_pkg::STOP_DIR : dir_s6;
		end
	end

	assign out_valid = v_s7;
	assign duty      = duty_s7;
	assign dir       = dir_s7;

endmodule

>>> hw/rtl/omni_wheel_polar_mixer.sv
// Top level of the four-wheel omni drive polar mixer.
//
// channel | direction | handshake         | contents
// s       | in        | s_tvalid/s_tready | heading, power, rotation command
// m       | out       | m_tvalid/m_tready | duty and direction for four wheels
// cfg     | in        | cfg_we            | per-wheel gain registers 0..3
//
// Seven register stages: angle, sine, power multiply, gain multiply, sum,
// rounding, reciprocal divide. One word per cycle while the output is not stalled.
// Reset clears the pipeline valids and sets every gain to 100.
// A stall at the output backs up only as far as the first empty stage.
module omni_wheel_polar_mixer #(
	parameter int DUTY_BITS = omp_pkg::DUTY_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// heading_deg[8:0], power_percent[16:9], rotation_cmd[24:17], zero pad
	input  logic [omp_pkg::IN_W-1:0]        s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// duty_one, dir_one, duty_two, dir_two, duty_three, dir_three,
	// duty_four, dir_four, zero pad
	output logic [((omp_pkg::NUM_WHEELS*(DUTY_BITS+1)+7)/8)*8-1:0] m_tdata,
	input  logic                            cfg_we,
	input  logic [omp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [omp_pkg::GAIN_W-1:0]      cfg_data
);

	localparam int OUT_W = ((omp_pkg::NUM_WHEELS * (DUTY_BITS + 1) + 7) / 8) * 8;
	localparam int LANE  = DUTY_BITS + 1;

	omp_pkg::gain_vec_t gain_q;
	omp_pkg::cmd_t      cmd;
	omp_pkg::trig_t     trig;
	omp_pkg::mix_t      mix;
	logic               trig_valid, trig_ready;
	logic               mix_valid, mix_ready;
	logic [omp_pkg::NUM_WHEELS-1:0][DUTY_BITS-1:0] duty;
	logic [omp_pkg::NUM_WHEELS-1:0]                dir;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < omp_pkg::NUM_WHEELS; w++) begin
				gain_q[w] <= omp_pkg::GAIN_RESET;
			end
		end else if (cfg_we) begin
			unique case (omp_pkg::cfg_reg_t'(cfg_index))
				omp_pkg::REG_GAIN_ONE:   gain_q[0] <= cfg_data;
				omp_pkg::REG_GAIN_TWO:   gain_q[1] <= cfg_data;
				omp_pkg::REG_GAIN_THREE: gain_q[2] <= cfg_data;
				omp_pkg::REG_GAIN_FOUR:  gain_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cmd = omp_pkg::cmd_t'(s_tdata[$bits(omp_pkg::cmd_t)-1:0]);

	omp_angle u_angle (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (cmd),
		.out_valid (trig_valid),
		.out_ready (trig_ready),
		.out_trig  (trig)
	);

	omp_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (trig_valid),
		.in_ready  (trig_ready),
		.in_trig   (trig),
		.gain      (gain_q),
		.out_valid (mix_valid),
		.out_ready (mix_ready),
		.out_mix   (mix)
	);

	omp_duty #(
		.DUTY_BITS (DUTY_BITS)
	) u_duty (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mix_valid),
		.in_ready  (mix_ready),
		.in_mix    (mix),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.duty      (duty),
		.dir       (dir)
	);

	always_comb begin
		m_tdata = '0;
		for (int w = 0; w < omp_pkg::NUM_WHEELS; w++) begin
			m_tdata[w*LANE +: DUTY_BITS] = duty[w];
			m_tdata[w*LANE + DUTY_BITS]  = dir[w];
		end
	end

endmodule

>>> hw/rtl/omp_checker.sv
// Port-level assertions for the polar mixer, bound to the top level.
module omp_checker #(
	parameter int OUT_W = 48
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	// no word can reach the output in the first cycle out of reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !m_tvalid)
		else $error("output word right after reset");

	// an empty or draining output stage lets the whole pipe move
	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input stalled while output stage is free");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output word dropped under stall");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output word changed under stall");

endmodule

bind omni_wheel_polar_mixer omp_checker #(
	.OUT_W (OUT_W)
) u_omp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> dv/tb.sv
// Testbench for the omni wheel polar mixer: random and corner commands checked against a predictor.
`timescale 1ns / 100ps

module tb;

	import omp_pkg::*;

	localparam int DUTY_BITS = DUTY_BITS_DEF;
	localparam int OUT_W     = ((NUM_WHEELS * (DUTY_BITS + 1) + 7) / 8) * 8;
	localparam longint DMAX       = (longint'(1) << DUTY_BITS) - 1;
	localparam longint FULL_SCALE = 163840000;
	localparam longint ROT_STEP   = 1474560;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int SETTLE_CYCLES  = 16;
	localparam int LONG_HOLD      = 150;
	localparam int HOLD_AFTER     = 300;
	localparam int PHASE_CMDS     = 118;

	// wheel offsets in degrees, one to four
	localparam int WHEEL_OFF [NUM_WHEELS] = '{30, 150, 225, 315};
	localparam logic [NUM_WHEELS-1:0] STOP_DIRS = 4'b0011;

	// round(sin(d) * 16384), d = 0..90
	localparam int QSINE [91] = '{
		0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
		2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
		5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
		8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
		10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
		12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
		14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
		15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
		16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
		16384
	};

	typedef struct packed {
		logic [NUM_WHEELS-1:0][DUTY_BITS-1:0] duty;
		logic [NUM_WHEELS-1:0]                dir;
	} wheel_drive_t;

	typedef enum int {
		RDY_ALWAYS,
		RDY_LIGHT,
		RDY_ALTERNATE,
		RDY_HEAVY
	} rdy_mode_t;

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_W-1:0]        s_tdata   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_W-1:0]       m_tdata;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [GAIN_W-1:0]      cfg_data  = '0;

	logic [IN_W-1:0] cmd_q [$];
	wheel_drive_t    wheel_drive_q [$];
	int              gain_set [NUM_WHEELS] = '{100, 100, 100, 100};
	int              err_cnt = 0;
	int              results_seen = 0;

	omni_wheel_polar_mixer #(
		.DUTY_BITS(DUTY_BITS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic wheel_drive_t mix_wheels(logic [IN_W-1:0] c);
		wheel_drive_t r;
		int           hd;
		int           ang;
		longint       pw;
		longint       rt;
		longint       sn;
		longint       s;
		longint       mag;
		longint       duty;
		r = '0;
		hd = int'(c[8:0]) % 360;
		pw = longint'($signed(c[16:9]));
		rt = longint'($signed(c[24:17]));
		if (pw == 0) begin
			r.dir = STOP_DIRS;
			return r;
		end
		for (int w = 0; w < NUM_WHEELS; w++) begin
			ang = (90 + WHEEL_OFF[w] + 360 - hd) % 360;
			if (ang <= 90)
				sn = QSINE[ang];
			else if (ang <= 180)
				sn = QSINE[180 - ang];
			else if (ang <= 270)
				sn = -QSINE[ang - 180];
			else
				sn = -QSINE[360 - ang];
			s = sn * pw * longint'(gain_set[w]) + rt * ROT_STEP;
			mag = (s < 0) ? -s : s;
			duty = (mag * DMAX + FULL_SCALE / 2) / FULL_SCALE;
			if (duty > DMAX)
				duty = DMAX;
			r.duty[w] = duty[DUTY_BITS-1:0];
			r.dir[w] = (s > 0);
		end
		return r;
	endfunction

	task automatic report_error(string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		err_cnt++;
	endtask

	task automatic add_cmd(logic [8:0] hd, logic [7:0] pw, logic [7:0] rt);
		cmd_q.push_back({7'b0, rt, pw, hd});
	endtask

	task automatic add_random_cmd();
		logic [8:0] hd;
		logic [7:0] pw;
		logic [7:0] rt;
		if ($urandom_range(0, 15) == 0)
			hd = 9'($urandom_range(360, 511));
		else
			hd = 9'($urandom_range(0, 359));
		case ($urandom_range(0, 15))
			0:       pw = 8'd0;
			1:       pw = 8'($urandom_range(0, 255));
			default: pw = 8'(int'($urandom_range(0, 200)) - 100);
		endcase
		rt = 8'($urandom_range(0, 255));
		add_cmd(hd, pw, rt);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [GAIN_W-1:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		gain_set[idx] = int'(v);
	endtask

	task automatic load_gains(int g1, int g2, int g3, int g4);
		write_reg(REG_GAIN_ONE, 8'(g1));
		write_reg(REG_GAIN_TWO, 8'(g2));
		write_reg(REG_GAIN_THREE, 8'(g3));
		write_reg(REG_GAIN_FOUR, 8'(g4));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until every queued command has come back out, then let the pipe go quiet
	task automatic drain_pipeline();
		while (cmd_q.size() != 0 || wheel_drive_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// sender: bursts of words with random gaps
	logic [IN_W-1:0] sent_cmd;
	logic            busy_word;
	int              burst_left = 1;
	int              gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			busy_word = s_tvalid;
			if (s_tvalid && s_tready) begin
				sent_cmd = cmd_q.pop_front();
				wheel_drive_q.push_back(mix_wheels(sent_cmd));
				busy_word = 1'b0;
			end
			if (!busy_word) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (cmd_q.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= cmd_q[0];
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each word, stalls on a mode that changes now and then
	wheel_drive_t want;
	rdy_mode_t    rdy_mode = RDY_ALWAYS;
	int           mode_left = 0;
	int           hold_left = 0;
	logic         long_hold_done = 1'b0;
	logic         alt_phase = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (wheel_drive_q.size() == 0) begin
					report_error($sformatf("result word 0x%0h with nothing expected", m_tdata));
				end else begin
					want = wheel_drive_q.pop_front();
					for (int w = 0; w < NUM_WHEELS; w++) begin
						if (m_tdata[w*(DUTY_BITS+1) +: DUTY_BITS] !== want.duty[w])
							report_error($sformatf("wheel %0d duty %0d, expected %0d", w + 1,
								m_tdata[w*(DUTY_BITS+1) +: DUTY_BITS], want.duty[w]));
						if (m_tdata[w*(DUTY_BITS+1) + DUTY_BITS] !== want.dir[w])
							report_error($sformatf("wheel %0d dir %0b, expected %0b", w + 1,
								m_tdata[w*(DUTY_BITS+1) + DUTY_BITS], want.dir[w]));
					end
				end
			end
			alt_phase = ~alt_phase;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
				// long back-pressure so the pipe fills and input stalls
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD - 1;
				m_tready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					rdy_mode = rdy_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 200);
				end else begin
					mode_left--;
				end
				case (rdy_mode)
					RDY_ALWAYS:    m_tready <= 1'b1;
					RDY_LIGHT:     m_tready <= ($urandom_range(0, 3) != 0);
					RDY_ALTERNATE: m_tready <= alt_phase;
					default:       m_tready <= ($urandom_range(0, 9) < 3);
				endcase
			end
		end
	end

	initial begin
		for (int n = 0; n < CYCLE_LIMIT; n++)
			@(posedge clk);
		$display("simulation failed");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset gains: extremes, stop, zero term, tiny term, heading wrap
		add_cmd(9'd0, 8'd100, 8'd0);
		add_cmd(9'd359, -8'sd100, 8'd127);
		add_cmd(9'd511, 8'd127, 8'h80);
		add_cmd(9'd360, 8'h80, 8'd127);
		add_cmd(9'd90, 8'd0, 8'd77);
		add_cmd(9'd0, 8'd0, 8'h80);
		add_cmd(9'd120, 8'd50, 8'd0);      // wheel one term exactly zero
		add_cmd(9'd119, 8'd1, 8'd0);       // wheel one rounds to zero, dir stays high
		add_cmd(9'd180, 8'd1, 8'hFF);
		add_cmd(9'd270, 8'hFF, 8'd1);
		add_cmd(9'd45, 8'd100, 8'd127);
		add_cmd(9'd255, 8'd73, 8'hC0);
		drain_pipeline();

		load_gains(255, 0, 200, 1);
		add_cmd(9'd300, 8'd127, 8'd127);
		add_cmd(9'd119, 8'd1, 8'd0);
		add_cmd(9'd480, -8'sd100, 8'd0);
		add_cmd(9'd30, 8'd0, 8'd5);
		add_cmd(9'd211, 8'd1, 8'd0);
		drain_pipeline();

		for (int p = 0; p < 8; p++) begin
			case (p)
				0:       load_gains(0, 0, 0, 0);
				1:       load_gains(255, 255, 255, 255);
				2:       load_gains(200, 200, 200, 200);
				3:       load_gains(100, 100, 100, 100);
				4:       load_gains($urandom_range(0, 255), $urandom_range(0, 255),
						$urandom_range(0, 255), $urandom_range(0, 255));
				default: load_gains($urandom_range(0, 200), $urandom_range(0, 200),
						$urandom_range(0, 200), $urandom_range(0, 200));
			endcase
			for (int i = 0; i < PHASE_CMDS; i++)
				add_random_cmd();
			drain_pipeline();
		end

		if (err_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/omp_pkg.sv
hw/rtl/omp_angle.sv
hw/rtl/omp_scale.sv
hw/rtl/omp_duty.sv
hw/rtl/omni_wheel_polar_mixer.sv
hw/rtl/omp_checker.sv
dv/tb.sv
